@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, held off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/atkd_pkg.sv @@
// ---------------------------------------------------------------------------
// atkd_pkg
// Types, constants and helper functions of the Atkinson dither stream core.
// ---------------------------------------------------------------------------
package atkd_pkg;

   // Sizing
   localparam int MAX_WIDTH     = 4096;
   localparam int ERROR_BITS    = 13;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = 16;
   localparam int PIX_BITS      = 8;
   // pixel * 8 plus one error fits one bit above the error width
   localparam int SUM_BITS      = ERROR_BITS + 1;
   // quantized value and its error: the sum divided by eight, plus margin
   localparam int QVAL_BITS     = ERROR_BITS - 1;

   // Configuration registers
   localparam int THR_BITS      = 9;
   localparam int FW_BITS       = 13;
   localparam int FH_BITS       = 16;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [THR_BITS-1:0] THRESHOLD_RESET    = THR_BITS'(128);
   localparam logic [FW_BITS-1:0]  FRAME_WIDTH_RESET  = FW_BITS'(640);
   localparam logic [FH_BITS-1:0]  FRAME_HEIGHT_RESET = FH_BITS'(480);

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_THRESHOLD    = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   // Output levels
   localparam logic [PIX_BITS-1:0] PIX_WHITE = 8'hFF;
   localparam logic [PIX_BITS-1:0] PIX_BLACK = 8'h00;
   localparam int                  WHITE_LEVEL = 255;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   typedef logic signed [ERROR_BITS-1:0] err_type;
   typedef logic signed [QVAL_BITS-1:0]  qval_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   // Result item as it waits in the queue
   typedef struct packed {
      logic                frame_end;
      logic                row_end;
      logic [PIX_BITS-1:0] pixel;
   } rsp_item_type;

   // Per-pixel control carried from the read stage to the update stage
   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic [PIX_BITS-1:0] pixel;
      logic                left_ok;
      logic                right;
      logic                right2;
      logic                down;
      logic                down2;
      logic                row_end;
      logic                frame_end;
   } pix_ctl_type;

   // Saturating add in the error store range
   function automatic err_type sat_add(input err_type a, input err_type b);
      logic signed [ERROR_BITS:0] sum;
      err_type                    res;
      sum = {a[ERROR_BITS-1], a} + {b[ERROR_BITS-1], b};
      if (sum[ERROR_BITS] != sum[ERROR_BITS-1]) begin
         res = sum[ERROR_BITS] ? {1'b1, {(ERROR_BITS-1){1'b0}}}
                               : {1'b0, {(ERROR_BITS-1){1'b1}}};
      end else begin
         res = sum[ERROR_BITS-1:0];
      end
      return res;
   endfunction

   // Sign-extend a quantization error to the store width
   function automatic err_type err_ext(input qval_type v);
      return {{(ERROR_BITS-QVAL_BITS){v[QVAL_BITS-1]}}, v};
   endfunction

endpackage

@@ rtl/atkd_ram.sv @@
// ---------------------------------------------------------------------------
// atkd_ram
// Generic single-write, single-read RAM with a registered read port.
// A read at the address being written returns the old contents.
// ---------------------------------------------------------------------------
module atkd_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/atkinson_dither_stream_core.sv @@
// ---------------------------------------------------------------------------
// atkinson_dither_stream_core
// Streaming Atkinson ditherer for 8-bit grey pixels in raster order.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while req_tready is high and returns one dithered
// pixel (0 or 255) per pixel, in order, via stage two and the result queue.
// After reset the block sweeps its three 4096-entry error memories to zero,
// one entry per cycle, and holds req_tready low throughout; CSR writes are
// taken during the sweep. The sustained rate is one pixel per clock while
// rsp_tready is high, set by the error update stage, which closes the same-row
// error loop from one pixel to the next. A four-entry result queue lets the
// block keep accepting pixels while results wait on rsp_tready. Errors are held
// in signed 13-bit eighths and saturate. Change registers only while the block
// is idle; a change takes effect on the next pixel without clearing state.
// ---------------------------------------------------------------------------
module atkinson_dither_stream_core import atkd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // pixel input
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] pixel_in
   // dithered output
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,   // [7:0] pixel_out
   output logic                     rsp_tlast,   // row_end
   output logic                     rsp_tuser,   // [0] frame_end
   // register writes
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [THR_BITS-1:0] threshold_ff;
   logic [FW_BITS-1:0]  frame_width_ff;
   logic [FH_BITS-1:0]  frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_THRESHOLD:    threshold_ff    <= csr_wdata[THR_BITS-1:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FW_BITS-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Clearing sweep state machine
   // ------------------------------------------------------------------
   state_type           state_ff, state_in;
   logic [COL_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                clearing;
   logic                clr_last;

   assign clr_last = (clr_addr_ff == COL_BITS'(MAX_WIDTH - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_RUN;
         ST_RUN:   state_in = ST_RUN;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      clearing    = 1'b0;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clearing    = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_RUN:   clearing = 1'b0;
         default:  clearing = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage one: position, frame edges and memory reads
   // ------------------------------------------------------------------
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [FW_BITS-1:0]  fw_m1;
   logic [COL_BITS-1:0] last_col;
   logic [ROW_BITS-1:0] last_row;
   logic [COL_BITS-1:0] cur_x;
   logic [ROW_BITS-1:0] cur_y;
   logic [COL_BITS:0]   x_plus1;
   logic [ROW_BITS:0]   y_plus1;
   pix_ctl_type         a_ctl;
   logic                req_accept;

   assign req_accept = req_tvalid & req_tready;
   assign fw_m1      = frame_width_ff - 1'b1;

   // Clamp the frame size and the counters into range
   always_comb begin
      if (frame_width_ff == '0) begin
         last_col = '0;
      end else if (frame_width_ff > FW_BITS'(MAX_WIDTH)) begin
         last_col = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         last_col = fw_m1[COL_BITS-1:0];
      end
      last_row = (frame_height_ff == '0) ? '0 : frame_height_ff - 1'b1;
      cur_x    = (col_ff > last_col) ? last_col : col_ff;
      cur_y    = (row_ff > last_row) ? last_row : row_ff;
      x_plus1  = {1'b0, cur_x} + 1'b1;
      y_plus1  = {1'b0, cur_y} + 1'b1;
   end

   // Neighbor flags of the current pixel
   always_comb begin
      a_ctl.col       = cur_x;
      a_ctl.pixel     = req_tdata[PIX_BITS-1:0];
      a_ctl.left_ok   = (cur_x != '0);
      a_ctl.right     = (cur_x != last_col);
      a_ctl.right2    = (x_plus1 < {1'b0, last_col});
      a_ctl.down      = (cur_y != last_row);
      a_ctl.down2     = (y_plus1 < {1'b0, last_row});
      a_ctl.row_end   = (cur_x == last_col);
      a_ctl.frame_end = (cur_x == last_col) && (cur_y == last_row);
   end

   // Advance the raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (a_ctl.row_end) begin
            col_in = '0;
            row_in = a_ctl.frame_end ? '0 : y_plus1[ROW_BITS-1:0];
         end else begin
            col_in = x_plus1[COL_BITS-1:0];
            row_in = cur_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // Error memories: two copies of the next-row store (column and column
   // minus one), one second-row store
   // ------------------------------------------------------------------
   logic                nre_we;
   logic [COL_BITS-1:0] nre_wa;
   err_type             nre_wd;
   err_type             nre_rd_cur, nre_rd_left;
   logic                sre_we;
   logic [COL_BITS-1:0] sre_wa;
   err_type             sre_wd;
   err_type             sre_rd;
   logic [COL_BITS-1:0] cur_xm1;

   assign cur_xm1 = cur_x - 1'b1;

   atkd_ram #(.WIDTH(ERROR_BITS), .DEPTH(MAX_WIDTH)) u_nre_cur_ram (
      .clock   (clock),
      .wr_en   (nre_we),
      .wr_addr (nre_wa),
      .wr_data (nre_wd),
      .rd_addr (cur_x),
      .rd_data (nre_rd_cur)
   );

   atkd_ram #(.WIDTH(ERROR_BITS), .DEPTH(MAX_WIDTH)) u_nre_left_ram (
      .clock   (clock),
      .wr_en   (nre_we),
      .wr_addr (nre_wa),
      .wr_data (nre_wd),
      .rd_addr (cur_xm1),
      .rd_data (nre_rd_left)
   );

   atkd_ram #(.WIDTH(ERROR_BITS), .DEPTH(MAX_WIDTH)) u_sre_ram (
      .clock   (clock),
      .wr_en   (sre_we),
      .wr_addr (sre_wa),
      .wr_data (sre_wd),
      .rd_addr (cur_x),
      .rd_data (sre_rd)
   );

   // ------------------------------------------------------------------
   // Stage two registers
   // ------------------------------------------------------------------
   logic        b_valid_ff;
   pix_ctl_type b_ctl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         b_ctl_ff <= a_ctl;
      end
   end

   // ------------------------------------------------------------------
   // Forwarding state: the pending next-row value of the previous pixel
   // and the last write of each memory
   // ------------------------------------------------------------------
   logic                pend_valid_ff, pend_valid_in;
   logic [COL_BITS-1:0] pend_addr_ff, pend_addr_in;
   err_type             pend_data_ff, pend_data_in;
   logic                nlw_valid_ff;
   logic [COL_BITS-1:0] nlw_addr_ff;
   err_type             nlw_data_ff;
   logic                slw_valid_ff;
   logic [COL_BITS-1:0] slw_addr_ff;
   err_type             slw_data_ff;

   // ------------------------------------------------------------------
   // Stage two: quantize and diffuse
   // ------------------------------------------------------------------
   err_type                ahead1_ff, ahead1_in;
   qval_type               ahead2_ff, ahead2_in;
   qval_type               diag_ff, diag_in;
   logic [COL_BITS-1:0]    b_xm1;
   err_type                nre_cur, nre_left, sre_cur;
   err_type                total;
   logic signed [SUM_BITS-1:0] sum_s, sum_adj, sum_div;
   qval_type               newval;
   logic                   white;
   qval_type               qerr;
   err_type                qerr_ext;
   err_type                nre_new;
   err_type                left_new;
   logic                   merge_left;

   assign b_xm1      = b_ctl_ff.col - 1'b1;
   assign merge_left = b_ctl_ff.left_ok && b_ctl_ff.down;

   // Pick the newest value of each store entry
   always_comb begin
      if (pend_valid_ff && (pend_addr_ff == b_ctl_ff.col)) begin
         nre_cur = pend_data_ff;
      end else if (nlw_valid_ff && (nlw_addr_ff == b_ctl_ff.col)) begin
         nre_cur = nlw_data_ff;
      end else begin
         nre_cur = nre_rd_cur;
      end
      if (pend_valid_ff && (pend_addr_ff == b_xm1)) begin
         nre_left = pend_data_ff;
      end else if (nlw_valid_ff && (nlw_addr_ff == b_xm1)) begin
         nre_left = nlw_data_ff;
      end else begin
         nre_left = nre_rd_left;
      end
      if (slw_valid_ff && (slw_addr_ff == b_ctl_ff.col)) begin
         sre_cur = slw_data_ff;
      end else begin
         sre_cur = sre_rd;
      end
   end

   // Add the diffused error, truncate toward zero, threshold
   always_comb begin
      total    = sat_add(nre_cur, ahead1_ff);
      sum_s    = $signed({{(SUM_BITS-PIX_BITS-3){1'b0}}, b_ctl_ff.pixel, 3'b000})
               + {total[ERROR_BITS-1], total};
      sum_adj  = sum_s[SUM_BITS-1] ? sum_s + SUM_BITS'(7) : sum_s;
      sum_div  = sum_adj >>> 3;
      newval   = sum_div[QVAL_BITS-1:0];
      white    = newval >= $signed({{(QVAL_BITS-THR_BITS){1'b0}}, threshold_ff});
      qerr     = white ? newval - QVAL_BITS'(WHITE_LEVEL) : newval;
      qerr_ext = err_ext(qerr);
   end

   // New store values
   always_comb begin
      nre_new  = b_ctl_ff.down ? sat_add(sat_add(sre_cur, err_ext(diag_ff)), qerr_ext)
                               : '0;
      left_new = sat_add(nre_left, qerr_ext);
   end

   // Same-row and diagonal carries
   always_comb begin
      ahead1_in = ahead1_ff;
      ahead2_in = ahead2_ff;
      diag_in   = diag_ff;
      if (b_valid_ff) begin
         ahead1_in = b_ctl_ff.right ? sat_add(err_ext(ahead2_ff), qerr_ext) : '0;
         ahead2_in = b_ctl_ff.right2 ? qerr : '0;
         diag_in   = (b_ctl_ff.down && b_ctl_ff.right) ? qerr : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ahead1_ff <= '0;
         ahead2_ff <= '0;
         diag_ff   <= '0;
      end else begin
         ahead1_ff <= ahead1_in;
         ahead2_ff <= ahead2_in;
         diag_ff   <= diag_in;
      end
   end

   // ------------------------------------------------------------------
   // Memory write port control
   // ------------------------------------------------------------------
   // Next-row store: write zeros in the sweep, else the pending value of the
   // previous column, with this pixel's error folded in, or update column-1 alone.
   always_comb begin
      nre_we = 1'b0;
      nre_wa = pend_addr_ff;
      nre_wd = pend_data_ff;
      if (clearing) begin
         nre_we = 1'b1;
         nre_wa = clr_addr_ff;
         nre_wd = '0;
      end else if (pend_valid_ff) begin
         nre_we = 1'b1;
         if (b_valid_ff && merge_left && (pend_addr_ff == b_xm1)) begin
            nre_wd = left_new;
         end
      end else if (b_valid_ff && merge_left) begin
         nre_we = 1'b1;
         nre_wa = b_xm1;
         nre_wd = left_new;
      end
   end

   // Hold this pixel's next-row value for one pixel; flush it when idle
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      if (b_valid_ff) begin
         pend_valid_in = 1'b1;
         pend_addr_in  = b_ctl_ff.col;
         pend_data_in  = nre_new;
      end else if (!clearing) begin
         pend_valid_in = 1'b0;
      end
   end

   // Second-row store: zeroed during the sweep, then written once per pixel
   always_comb begin
      sre_we = 1'b0;
      sre_wa = b_ctl_ff.col;
      sre_wd = b_ctl_ff.down2 ? qerr_ext : '0;
      if (clearing) begin
         sre_we = 1'b1;
         sre_wa = clr_addr_ff;
         sre_wd = '0;
      end else if (b_valid_ff) begin
         sre_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         nlw_valid_ff  <= 1'b0;
         slw_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         nlw_valid_ff  <= nre_we;
         slw_valid_ff  <= sre_we;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      nlw_addr_ff  <= nre_wa;
      nlw_data_ff  <= nre_wd;
      slw_addr_ff  <= sre_wa;
      slw_data_ff  <= sre_wd;
   end

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   rsp_item_type         q_item_ff [QUEUE_DEPTH];
   rsp_item_type         push_item;
   logic [QPTR_BITS-1:0] q_wr_ff, q_wr_in;
   logic [QPTR_BITS-1:0] q_rd_ff, q_rd_in;
   logic [QCNT_BITS-1:0] q_cnt_ff, q_cnt_in;
   logic [QCNT_BITS-1:0] q_load;
   logic                 rsp_accept;

   assign push_item.frame_end = b_ctl_ff.frame_end;
   assign push_item.row_end   = b_ctl_ff.row_end;
   assign push_item.pixel     = white ? PIX_WHITE : PIX_BLACK;

   assign rsp_accept = rsp_tvalid & rsp_tready;

   // Advance the queue pointers and count
   always_comb begin
      q_wr_in  = b_valid_ff ? q_wr_ff + 1'b1 : q_wr_ff;
      q_rd_in  = rsp_accept ? q_rd_ff + 1'b1 : q_rd_ff;
      q_cnt_in = q_cnt_ff + QCNT_BITS'(b_valid_ff) - QCNT_BITS'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_in;
         q_rd_ff  <= q_rd_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         q_item_ff[q_wr_ff] <= push_item;
      end
   end

   // Accept only while the queue has room for everything in flight
   assign q_load     = q_cnt_ff + QCNT_BITS'(b_valid_ff);
   assign req_tready = !clearing && (q_load <= QCNT_BITS'(QUEUE_DEPTH - 1));

   assign rsp_tvalid = (q_cnt_ff != '0);
   assign rsp_tdata  = q_item_ff[q_rd_ff].pixel;
   assign rsp_tlast  = q_item_ff[q_rd_ff].row_end;
   assign rsp_tuser  = q_item_ff[q_rd_ff].frame_end;

endmodule

@@ rtl/atkd_checker.sv @@
// ---------------------------------------------------------------------------
// atkd_checker
// Port-level checks of the Atkinson dither stream core, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module atkd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // Output pixels are pure black or white
   `ASSERT_IMPLY(a_pixel_level, clock, reset, rsp_tvalid, (rsp_tdata == 8'hFF) || (rsp_tdata == 8'h00))

   // The end of a frame is always the end of a row
   `ASSERT_IMPLY(a_frame_ends_row, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)

   // No transaction is taken as the memory sweep starts after reset
   `ASSERT_IMPLY(a_sweep_after_reset, clock, reset, $past(reset), !req_tready)

   // A stalled result holds until it is taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule

bind atkinson_dither_stream_core atkd_checker u_atkd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
